[design/kti_pkg.sv]
// Package for the keyframe track interpolator: opcodes, status codes, key types.
// No dependencies.
`default_nettype none
package kti_pkg;
	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_SET = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [2:0] TY_LIN = 3'd1;
	localparam logic [2:0] TY_L16 = 3'd2;
	localparam logic [2:0] TY_L8  = 3'd3;
	localparam logic [2:0] TY_L4  = 3'd4;

	// per-cell shift command
	typedef struct packed {
		logic ins;
		logic del;
		logic wr;
	} kti_cmd_t;
endpackage
`default_nettype wire

[design/keyframe_track_interpolator.sv]
// Keyframe track interpolator top level: cell chain, sequencer, lane interpolator.
// Depends on kti_pkg, kti_cell, kti_lerp.
//
// Slave channel s_axis_* carries one command beat; master channel m_axis_* returns one
// result beat per command. The table is a chain of MAX_KEYS cells, each comparing its
// row with the query in parallel; set and delete shift all cells of the chain at once.
// A command passes through states T_FIND, T_GET and T_OUT before m_axis_tvalid rises;
// a get between two keys also waits in T_WAIT for the lane interpolator, which returns
// the lower key's value directly for a step key and otherwise runs, for each lane, a
// shift-add multiply, a restoring divide and one merge step.
// One command at a time; the next is taken only once the result beat has gone.
// A stalled receiver holds the result beat and the input. Reset empties the table.
`default_nettype none
module keyframe_track_interpolator
	import kti_pkg::*;
#(
	parameter int MAX_KEYS = 256,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// opcode[1:0], key_row[33:2], row_fraction[49:34], key_value[81:50], key_type[84:82]
	input  wire logic [87:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// track_value[31:0], status[33:32], keys_held[42:34]
	output logic      [47:0] m_axis_tdata
);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int IW = $clog2(MAX_KEYS);
	typedef enum logic [2:0] {T_IDLE, T_FIND, T_GET, T_WAIT, T_OUT} st_t;
	st_t st_q;
	logic [1:0]  op_q;
	logic [31:0] rowi_q, vali_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [2:0]  typi_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] rows [MAX_KEYS];
	logic [31:0] vals [MAX_KEYS];
	logic [2:0]  typs [MAX_KEYS];
	logic [MAX_KEYS-1:0] ge, hit;
	logic [CW-1:0] pos_q;
	logic hit_q;
	kti_cmd_t cmd;
	logic [31:0] tv_q;
	logic [1:0] stat_q;
	logic [31:0] v0_q, v1_q, dr_q, dn_q;
	logic [2:0] ty_q;
	logic ls, ld;
	logic [31:0] lres;
	logic [CW-1:0] pos_c;
	logic hit_c;
	logic ls_q;
	logic [IW-1:0] fi;

	genvar g;
	generate
		for (g = 0; g < MAX_KEYS; g++) begin : g_c
			assign ge[g] = (CW'(g) < cnt_q) &&
				((rows[g] ^ 32'h80000000) >= (rowi_q ^ 32'h80000000));
			assign hit[g] = (CW'(g) < cnt_q) && (rows[g] == rowi_q);
			kti_cell u_cell (
				.clk(clk), .cmd(cmd),
				.at_ge(CW'(g) >= pos_q),
				.at_hit(hit[g]),
				.prev_row(rows[g == 0 ? 0 : g-1]), .prev_val(vals[g == 0 ? 0 : g-1]),
				.prev_typ(typs[g == 0 ? 0 : g-1]),
				.prev_ge(CW'(g) > pos_q),
				.next_row(rows[g == MAX_KEYS-1 ? g : g+1]),
				.next_val(vals[g == MAX_KEYS-1 ? g : g+1]),
				.next_typ(typs[g == MAX_KEYS-1 ? g : g+1]),
				.new_row(rowi_q), .new_val(vali_q), .new_typ(typi_q),
				.row_q(rows[g]), .val_q(vals[g]), .typ_q(typs[g])
			);
		end
	endgenerate

	always_comb begin
		pos_c = cnt_q;
		for (int i = MAX_KEYS - 1; i >= 0; i--) if (ge[i]) pos_c = CW'(i);
		hit_c = |hit;
	end

	always_comb begin
		cmd = '0;
		if (st_q == T_GET) begin
			cmd.wr  = (op_q == OP_SET) && hit_q;
			cmd.ins = (op_q == OP_SET) && !hit_q && (cnt_q < CW'(MAX_KEYS));
			cmd.del = (op_q == OP_DEL) && hit_q;
		end
	end

	assign s_axis_tready = (st_q == T_IDLE) && !m_axis_tvalid;
	assign ls = (st_q == T_GET) && (op_q == OP_GET) && (cnt_q != '0) &&
		!(!hit_q && pos_q == '0) && ((pos_q + CW'(hit_q)) < cnt_q);
	assign m_axis_tdata = {5'd0, 9'(cnt_q), stat_q, tv_q};
	// floor key; first key before the start, last key past the end
	assign fi = (!hit_q && pos_q == '0) ? '0 :
		(hit_q ? pos_q[IW-1:0] : IW'(pos_q - CW'(1)));

	kti_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
		.clk(clk), .arst_n(arst_n), .start(ls_q),
		.typ(ty_q), .v0(v0_q), .v1(v1_q), .dr(dr_q), .dn(dn_q), .frac(frac_q),
		.done(ld), .res(lres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			cnt_q <= '0;
			m_axis_tvalid <= 1'b0;
			ls_q <= 1'b0;
		end else begin
			ls_q <= ls;
			if (st_q == T_OUT) m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (st_q)
				T_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					op_q <= s_axis_tdata[1:0];
					rowi_q <= s_axis_tdata[33:2];
					frac_q <= FRAC_BITS'(s_axis_tdata[49:34]);
					vali_q <= s_axis_tdata[81:50];
					typi_q <= s_axis_tdata[84:82];
					st_q <= T_FIND;
				end
				T_FIND: begin
					pos_q <= pos_c;
					hit_q <= hit_c;
					st_q <= T_GET;
				end
				T_GET: begin
					if (ls) begin
						v0_q <= vals[fi];
						v1_q <= vals[IW'(fi + IW'(1))];
						dr_q <= rowi_q - rows[fi];
						dn_q <= rows[IW'(fi + IW'(1))] - rows[fi];
						ty_q <= typs[fi];
						stat_q <= ST_OK;
						st_q <= T_WAIT;
					end else begin
						st_q <= T_OUT;
						if (op_q == OP_GET) begin
							tv_q <= (cnt_q == '0) ? '0 : vals[fi];
							stat_q <= ST_OK;
						end else begin
							tv_q <= '0;
							if (op_q == OP_SET) begin
								stat_q <= (cmd.ins || hit_q) ? ST_OK : ST_FULL;
								if (cmd.ins) cnt_q <= cnt_q + CW'(1);
							end else if (op_q == OP_DEL) begin
								stat_q <= hit_q ? ST_OK : ST_MISS;
								if (hit_q) cnt_q <= cnt_q - CW'(1);
							end else begin
								stat_q <= ST_OK;
							end
						end
					end
				end
				T_WAIT: if (ld) begin
					tv_q <= lres;
					st_q <= T_OUT;
				end
				default: begin
					st_q <= T_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_KEYS))
		else $error("key count overflow");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == T_OUT) |=> m_axis_tvalid) else $error("result lost");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("beat dropped");
`endif
endmodule
`default_nettype wire

[design/kti_cell.sv]
// One key cell of the sorted table: holds row, value and type, shifts with neighbours.
// Depends on kti_pkg.
`default_nettype none
module kti_cell
	import kti_pkg::*;
(
	input  wire logic        clk,
	input  wire kti_cmd_t    cmd,
	input  wire logic        at_ge,
	input  wire logic        at_hit,
	input  wire logic [31:0] prev_row,
	input  wire logic [31:0] prev_val,
	input  wire logic [2:0]  prev_typ,
	input  wire logic        prev_ge,
	input  wire logic [31:0] next_row,
	input  wire logic [31:0] next_val,
	input  wire logic [2:0]  next_typ,
	input  wire logic [31:0] new_row,
	input  wire logic [31:0] new_val,
	input  wire logic [2:0]  new_typ,
	output logic      [31:0] row_q,
	output logic      [31:0] val_q,
	output logic      [2:0]  typ_q
);
	always_ff @(posedge clk) begin
		if (cmd.wr && at_hit) begin
			val_q <= new_val;
			typ_q <= new_typ;
		end else if (cmd.ins && at_ge) begin
			if (prev_ge) begin
				row_q <= prev_row;
				val_q <= prev_val;
				typ_q <= prev_typ;
			end else begin
				row_q <= new_row;
				val_q <= new_val;
				typ_q <= new_typ;
			end
		end else if (cmd.del && at_ge) begin
			row_q <= next_row;
			val_q <= next_val;
			typ_q <= next_typ;
		end
	end
endmodule
`default_nettype wire

[design/kti_lerp.sv]
// Serial lane interpolator: per lane, shift-add multiply of |d| by num, then restoring
// division by den. Depends on kti_pkg.
`default_nettype none
module kti_lerp
	import kti_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [2:0]  typ,
	input  wire logic [31:0] v0,
	input  wire logic [31:0] v1,
	input  wire logic [31:0] dr,
	input  wire logic [31:0] dn,
	input  wire logic [FRAC_BITS-1:0] frac,
	output logic             done,
	output logic      [31:0] res
);
	localparam int NW = 32 + FRAC_BITS;
	localparam int PW = NW + 33;
	localparam int QW = 7;
	localparam logic signed [PW+1:0] S_ONE = (PW+2)'(1);
	localparam logic signed [PW+1:0] S_ZERO = (PW+2)'(0);
	typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIN} st_t;
	st_t st_q;
	logic [5:0]  w_q;
	logic [5:0]  sh_q;
	logic [NW-1:0] num_q, den_q;
	logic [PW-1:0] prod_q;
	logic [NW:0] rem_q;
	logic [PW-1:0] quo_q;
	logic [QW-1:0] cnt_q;
	logic        neg_q;
	logic signed [33:0] a_q;
	logic [31:0] acc_q;
	logic [31:0] mask;
	logic        top;
	logic [4:0]  sb;
	logic signed [33:0] ia, ib, d;
	logic [32:0] mag;
	logic [NW:0] rsh;
	logic        rnz;
	logic signed [PW+1:0] s;
	logic [31:0] a0, b0;
	assign mask = (w_q == 6'd32) ? 32'hffffffff : ((32'd1 << w_q) - 32'd1);
	assign top = ({1'b0, sh_q} + {1'b0, w_q}) >= 7'd32;
	assign sb = 5'(w_q - 6'd1);
	assign a0 = (v0 >> sh_q) & mask;
	assign b0 = (v1 >> sh_q) & mask;
	// top lane is signed
	always_comb begin
		ia = $signed({2'b00, a0});
		ib = $signed({2'b00, b0});
		if (top && a0[sb]) ia = $signed({2'b00, a0}) - $signed(34'd1 << w_q);
		if (top && b0[sb]) ib = $signed({2'b00, b0}) - $signed(34'd1 << w_q);
		d = ib - ia;
		mag = d[33] ? 33'(-d) : d[32:0];
	end
	assign rsh = {rem_q[NW-1:0], prod_q[PW-1]};
	assign rnz = (rem_q != '0);
	always_comb begin
		s = neg_q ? -$signed({2'b00, quo_q}) - (rnz ? S_ONE : S_ZERO)
			: $signed({2'b00, quo_q});
		s = s + a_q;
		if (s < 0 && rnz) s = s + S_ONE;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (start) begin
					num_q <= {dr, frac};
					den_q <= {dn, {FRAC_BITS{1'b0}}};
					acc_q <= '0;
					sh_q <= '0;
					prod_q <= '0;
					cnt_q <= QW'(32);
					unique case (typ)
						TY_LIN: begin w_q <= 6'd32; st_q <= S_MUL; done <= 1'b0; end
						TY_L16: begin w_q <= 6'd16; st_q <= S_MUL; done <= 1'b0; end
						TY_L8:  begin w_q <= 6'd8;  st_q <= S_MUL; done <= 1'b0; end
						TY_L4:  begin w_q <= 6'd4;  st_q <= S_MUL; done <= 1'b0; end
						default: begin res <= v0; done <= 1'b1; end
					endcase
				end else begin
					done <= 1'b0;
				end
				S_MUL: begin
					done <= 1'b0;
					a_q <= ia;
					neg_q <= d[33];
					prod_q <= {prod_q[PW-2:0], 1'b0} + (mag[cnt_q[5:0]] ? PW'(num_q) : '0);
					if (cnt_q == '0) begin
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= QW'(PW - 1);
						st_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q - QW'(1);
					end
				end
				S_DIV: begin
					done <= 1'b0;
					if (rsh >= {1'b0, den_q}) begin
						rem_q <= rsh - {1'b0, den_q};
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
					prod_q <= {prod_q[PW-2:0], 1'b0};
					if (cnt_q == '0) st_q <= S_FIN;
					else cnt_q <= cnt_q - QW'(1);
				end
				default: begin
					acc_q <= acc_q | ((32'(s) & mask) << sh_q);
					done <= top;
					if (top) begin
						res <= acc_q | ((32'(s) & mask) << sh_q);
						st_q <= S_IDLE;
					end else begin
						sh_q <= sh_q + w_q;
						prod_q <= '0;
						cnt_q <= QW'(32);
						st_q <= S_MUL;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for keyframe_track_interpolator: drives command beats, predicts each result
// from its own sorted key table, and checks every result beat. Depends on kti_pkg.
`timescale 1ns / 1ps
module tb;
	import kti_pkg::*;

	localparam int NKEYS = 256;
	localparam logic [2:0] TY_STEP = 3'd0;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic [8:0]  held;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	keyframe_track_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	logic [31:0] tab_row [NKEYS];
	logic [31:0] tab_val [NKEYS];
	logic [2:0]  tab_typ [NKEYS];
	int          tab_n;
	res_t        pending [$];
	int          errors;
	int          send_idle;
	int          recv_idle;
	int          hold_cycles;
	int          n_results;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic int find_key(input logic [31:0] r, output bit hit);
		int lo, hi, mi;
		lo = 0; hi = tab_n; hit = 0;
		while (lo < hi) begin
			mi = lo + (hi - lo) / 2;
			if ($signed(tab_row[mi]) < $signed(r)) lo = mi + 1;
			else if ($signed(tab_row[mi]) > $signed(r)) hi = mi;
			else begin
				hit = 1;
				return mi;
			end
		end
		return lo;
	endfunction

	// trunc(a + (b-a)*num/den), exact
	function automatic logic signed [63:0] lane_mix(input logic signed [63:0] a,
			input logic signed [63:0] b, input logic [63:0] num, input logic [63:0] den);
		logic signed [127:0] p, q;
		p = $signed(128'(a)) * $signed({64'd0, den}) +
			$signed(128'(b - a)) * $signed({64'd0, num});
		q = p / $signed({64'd0, den});
		return q[63:0];
	endfunction

	function automatic logic [31:0] mix_lanes(input logic [31:0] v0, input logic [31:0] v1,
			input int w, input logic [63:0] num, input logic [63:0] den);
		logic [31:0] o;
		logic [63:0] a, b, m, r;
		o = 0;
		m = (64'd1 << w) - 1;
		for (int sh = 0; sh < 32; sh += w) begin
			a = (64'(v0) >> sh) & m;
			b = (64'(v1) >> sh) & m;
			if (sh + w >= 32) begin
				if (a[w-1]) a = a | ~m;
				if (b[w-1]) b = b | ~m;
			end
			r = lane_mix(a, b, num, den) & m;
			o = o | 32'(r << sh);
		end
		return o;
	endfunction

	function automatic logic [31:0] track_at(input logic [31:0] r, input logic [15:0] f);
		bit hit;
		int p, i;
		logic [63:0] num, den;
		if (tab_n == 0) return 0;
		p = find_key(r, hit);
		if (!hit && p == 0) return tab_val[0];
		i = hit ? p : p - 1;
		if (i + 1 >= tab_n) return tab_val[tab_n-1];
		num = (64'(32'(r - tab_row[i])) << 16) + f;
		den = 64'(32'(tab_row[i+1] - tab_row[i])) << 16;
		case (tab_typ[i])
			TY_LIN: return mix_lanes(tab_val[i], tab_val[i+1], 32, num, den);
			TY_L16: return mix_lanes(tab_val[i], tab_val[i+1], 16, num, den);
			TY_L8:  return mix_lanes(tab_val[i], tab_val[i+1], 8, num, den);
			TY_L4:  return mix_lanes(tab_val[i], tab_val[i+1], 4, num, den);
			default: return tab_val[i];
		endcase
	endfunction

	function automatic res_t apply_cmd(input logic [1:0] op, input logic [31:0] r,
			input logic [15:0] f, input logic [31:0] v, input logic [2:0] ty);
		res_t o;
		bit hit;
		int p;
		o = '0;
		if (op == OP_GET) begin
			o.value = track_at(r, f);
		end else if (op == OP_SET) begin
			p = find_key(r, hit);
			if (!hit) begin
				if (tab_n >= NKEYS) o.status = ST_FULL;
				else begin
					for (int i = tab_n; i > p; i--) begin
						tab_row[i] = tab_row[i-1];
						tab_val[i] = tab_val[i-1];
						tab_typ[i] = tab_typ[i-1];
					end
					tab_n++;
				end
			end
			if (o.status == ST_OK) begin
				tab_row[p] = r; tab_val[p] = v; tab_typ[p] = ty;
			end
		end else if (op == OP_DEL) begin
			p = find_key(r, hit);
			if (!hit) o.status = ST_MISS;
			else begin
				for (int i = p; i + 1 < tab_n; i++) begin
					tab_row[i] = tab_row[i+1];
					tab_val[i] = tab_val[i+1];
					tab_typ[i] = tab_typ[i+1];
				end
				tab_n--;
			end
		end
		o.held = 9'(tab_n);
		return o;
	endfunction

	task automatic send_cmd(input logic [1:0] op, input logic [31:0] r, input logic [15:0] f,
			input logic [31:0] v, input logic [2:0] ty);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {3'd0, ty, v, f, r, op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending.push_back(apply_cmd(op, r, f, v, ty));
		@(negedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	always @(posedge clk) begin
		res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[31:0], m_axis_tdata[33:32], m_axis_tdata[42:34]};
			n_results++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					$display("%0t: expected val %h st %0d n %0d, got val %h st %0d n %0d",
						$time, want.value, want.status, want.held,
						got.value, got.status, got.held);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic logic [31:0] rand_near(input logic [31:0] base);
		return base + 32'($urandom_range(40)) - 32'd20;
	endfunction

	task automatic test_directed;
		send_cmd(OP_GET, 32'h0, 16'hffff, 32'h0, TY_STEP);
		send_cmd(OP_DEL, 32'h5, 16'h0, 32'h0, TY_STEP);
		send_cmd(OP_SET, 32'h80000000, 16'h0, 32'h80000000, TY_LIN);
		send_cmd(OP_SET, 32'h7fffffff, 16'h0, 32'h7fffffff, TY_STEP);
		send_cmd(OP_GET, 32'h0, 16'h8000, 32'h0, TY_STEP);
		send_cmd(OP_GET, 32'h7fffffff, 16'hffff, 32'h0, TY_STEP);
		send_cmd(OP_SET, 32'h0, 16'h0, 32'hffffffff, TY_L16);
		send_cmd(OP_SET, 32'h10, 16'h0, 32'h0123_8765, TY_L8);
		send_cmd(OP_SET, 32'h20, 16'h0, 32'h8f7e_1a2b, TY_L4);
		send_cmd(OP_SET, 32'h30, 16'h0, 32'h5555_aaaa, 3'd7);
		send_cmd(OP_SET, 32'h40, 16'h0, 32'h0, 3'd5);
		send_cmd(OP_GET, 32'h7, 16'hffff, 32'h0, TY_STEP);
		send_cmd(OP_GET, 32'h17, 16'h1234, 32'h0, TY_STEP);
		send_cmd(OP_GET, 32'h2f, 16'hffff, 32'h0, TY_STEP);
		send_cmd(OP_GET, 32'h35, 16'h0, 32'h0, TY_STEP);
		send_cmd(OP_GET, 32'h80000000, 16'h0, 32'h0, TY_STEP);
		send_cmd(OP_GET, 32'hffffff00, 16'hffff, 32'h0, TY_STEP);
		send_cmd(OP_SET, 32'h10, 16'h0, 32'hfedc_ba98, TY_LIN);
		send_cmd(OP_DEL, 32'h10, 16'h0, 32'h0, TY_STEP);
		send_cmd(OP_DEL, 32'h10, 16'h0, 32'h0, TY_STEP);
		send_cmd(OP_GET, 32'h10, 16'h0, 32'h0, TY_STEP);
		drain();
	endtask

	task automatic test_full_table;
		for (int i = 0; i < NKEYS + 4; i++)
			send_cmd(OP_SET, 32'(i * 997 - 100000), 16'h0, $urandom, 3'($urandom_range(7)));
		send_cmd(OP_SET, 32'(5 * 997 - 100000), 16'h0, 32'h1234_5678, TY_LIN);
		for (int i = 0; i < 20; i++)
			send_cmd(OP_GET, 32'($urandom_range(260000) - 101000), 16'($urandom), 0, TY_STEP);
		for (int i = 0; i < NKEYS + 2; i++)
			send_cmd(OP_DEL, 32'(i * 997 - 100000), 16'h0, 32'h0, TY_STEP);
		drain();
	endtask

	task automatic test_random(input int count);
		logic [1:0] op;
		logic [31:0] r;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) op = OP_SET;
			else if (pick < 55) op = OP_DEL;
			else op = OP_GET;
			if ($urandom_range(9) == 0) r = $urandom;
			else if (tab_n > 0 && $urandom_range(1)) r = rand_near(tab_row[$urandom_range(tab_n-1)]);
			else r = 32'($urandom_range(400)) - 32'd200;
			send_cmd(op, r, 16'($urandom), $urandom, 3'($urandom_range(7)));
		end
	endtask

	task automatic test_backpressure;
		hold_cycles = 3000;
		for (int i = 0; i < 30; i++)
			send_cmd(($urandom_range(1) ? OP_GET : OP_SET), 32'($urandom_range(60)), 16'($urandom),
				$urandom, TY_LIN);
		drain();
	endtask

	initial begin
		errors = 0; n_results = 0; tab_n = 0; hold_cycles = 0;
		send_idle = 16; recv_idle = 52;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_table();
		test_random(520);
		drain();
		send_idle = 52; recv_idle = 16;
		test_random(450);
		test_backpressure();
		send_idle = 0; recv_idle = 0;
		test_random(390);
		drain();
		$display("Covered empty/full table, ends, every key type, delete misses and stalls;");
		$display("%0d result beats checked.", n_results);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#100ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

[files.f]
design/kti_pkg.sv
design/kti_cell.sv
design/kti_lerp.sv
design/keyframe_track_interpolator.sv
tb/tb.sv
